[hdl/cscl_pkg.sv]
// ----------------------------------------------------------------------------
// cscl_pkg: shared types and constants
// Request and result structs, fixed sample and output formats, and the
// sequencer state type of the clamped cosine similarity block.
// ----------------------------------------------------------------------------
package cscl_pkg;

  // Q1.15 input samples
  localparam int SAMPLE_BITS  = 16;
  // default vector length the sums are sized for
  localparam int MAX_ELEMENTS = 4096;
  // output format: unsigned Q1.15, SIM_ONE is 1.0
  localparam int SIM_FRAC     = 15;
  localparam int SIM_W        = SIM_FRAC + 1;
  localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << SIM_FRAC;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] a_value;
    logic signed [SAMPLE_BITS-1:0] b_value;
    logic                          last_element;
  } sample_t;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic             zero_norm;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_P,
    ST_MUL_T,
    ST_CLAMP,
    ST_BIT_A,
    ST_BIT_B,
    ST_BIT_C,
    ST_DONE
  } state_t;

endpackage

[hdl/cosine_similarity_clamped.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_clamped: streaming clamped cosine similarity
// Accumulates dot product and both squared norms over element pairs, then
// computes floor(32768 * dot / sqrt(na * nb)) clamped to [0, 32768] with a
// single shared wide adder under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                     Payload
//  -------  ---  ----------------------------  -----------------------------
//  sample   in   sample_valid / sample_stall   a_value, b_value, last_element
//  result   out  result_valid / result_stall   similarity, zero_norm
//
//  Pairs without last_element are taken one per cycle, back to back, while idle.
//  The final pair takes the block busy (sample_stall high) while the
//  sequencer runs: two shift-add multiplies over the ACC_W multiplier bits,
//  one clamp test, then states BIT_A, BIT_B and BIT_C for each of the 15
//  output bits; zero norm or non-positive dot goes from CHECK to DONE.
//  The result is held in an output register until result_stall is low;
//  sample_stall stays high until then. Sync reset clears sums and state.
//
module cosine_similarity_clamped #(
  parameter int MAX_ELEMENTS = cscl_pkg::MAX_ELEMENTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  cscl_pkg::sample_t  sample,
  output logic               result_valid,
  input  logic               result_stall,
  output cscl_pkg::result_t  result
);

  localparam int SB     = cscl_pkg::SAMPLE_BITS;
  localparam int PW     = 2 * SB;
  // sums cannot overflow within MAX_ELEMENTS pairs
  localparam int ACC_W  = PW + $clog2(MAX_ELEMENTS);
  // room for s^2 * na * nb and dot^2 * 2^30 plus one carry
  localparam int WIDE_W = 2 * ACC_W + 2 * cscl_pkg::SIM_FRAC + 2;
  localparam int CNT_W  = $clog2(ACC_W);
  localparam int BIT_W  = $clog2(cscl_pkg::SIM_FRAC);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);
  localparam logic [BIT_W-1:0] BIT_TOP  = BIT_W'(cscl_pkg::SIM_FRAC - 1);

  cscl_pkg::state_t state, state_next;

  // running sums
  logic signed [ACC_W-1:0] dot_sum, dot_sum_next;
  logic        [ACC_W-1:0] norm_a_sum, norm_a_sum_next;
  logic        [ACC_W-1:0] norm_b_sum, norm_b_sum_next;

  // sequencer datapath
  logic [WIDE_W-1:0] acc;      // multiply product, later s^2 * P
  logic [WIDE_W-1:0] mcand;    // shifted multiplicand, later partial candidate
  logic [ACC_W-1:0]  mplier;
  logic [WIDE_W-1:0] pk;       // P << 2k
  logic [WIDE_W-1:0] yv;       // (s * P) << (k+1)
  logic [WIDE_W-1:0] tref;     // dot^2 << 30
  logic [CNT_W-1:0]  cnt;
  logic [BIT_W-1:0]  bit_k;
  logic              take;
  logic [cscl_pkg::SIM_W-1:0] sim;
  logic              zn;

  logic              accept;
  logic              zero_norm_now;
  logic              dot_pos;

  // shared unit
  logic [WIDE_W-1:0] opa, opb, sum, cmp_lhs, mul_next;
  logic              fits;

  assign accept        = sample_valid && !sample_stall;
  assign zero_norm_now = (norm_a_sum == '0) || (norm_b_sum == '0);
  assign dot_pos       = !dot_sum[ACC_W-1] && (dot_sum != '0);

  // --------------------------------------------------------------------------
  // element accumulation with saturation
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]    prod_ab;
  logic        [PW-1:0]    prod_aa, prod_bb;
  logic signed [ACC_W:0]   dot_wide;
  logic        [ACC_W:0]   na_wide, nb_wide;

  always_comb begin
    prod_ab  = sample.a_value * sample.b_value;
    prod_aa  = sample.a_value * sample.a_value;
    prod_bb  = sample.b_value * sample.b_value;
    dot_wide = (ACC_W+1)'(dot_sum) + (ACC_W+1)'(prod_ab);
    na_wide  = {1'b0, norm_a_sum} + {{(ACC_W+1-PW){1'b0}}, prod_aa};
    nb_wide  = {1'b0, norm_b_sum} + {{(ACC_W+1-PW){1'b0}}, prod_bb};
  end

  always_comb begin
    dot_sum_next    = dot_sum;
    norm_a_sum_next = norm_a_sum;
    norm_b_sum_next = norm_b_sum;
    if (accept) begin
      if (dot_wide[ACC_W] != dot_wide[ACC_W-1]) begin
        // clamp to the signed range of the sum
        dot_sum_next = dot_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        dot_sum_next = dot_wide[ACC_W-1:0];
      end
      norm_a_sum_next = na_wide[ACC_W] ? '1 : na_wide[ACC_W-1:0];
      norm_b_sum_next = nb_wide[ACC_W] ? '1 : nb_wide[ACC_W-1:0];
    end else if (state != cscl_pkg::ST_DONE && state_next == cscl_pkg::ST_DONE) begin
      // result decided: sums start over
      dot_sum_next    = '0;
      norm_a_sum_next = '0;
      norm_b_sum_next = '0;
    end
  end

  // --------------------------------------------------------------------------
  // shared adder and compare
  // --------------------------------------------------------------------------
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state)
      cscl_pkg::ST_MUL_P, cscl_pkg::ST_MUL_T: begin
        opa = acc;
        opb = mcand;
      end
      cscl_pkg::ST_BIT_A: begin
        opa = acc;
        opb = yv;
      end
      cscl_pkg::ST_BIT_B: begin
        opa = mcand;
        opb = pk;
      end
      cscl_pkg::ST_BIT_C: begin
        opa = yv;
        opb = take ? (pk << 1) : '0;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    sum      = opa + opb;
    mul_next = mplier[0] ? sum : acc;
    // clamp test compares P << 30 against dot^2 << 30
    cmp_lhs  = (state == cscl_pkg::ST_CLAMP) ? (pk << 2) : sum;
    fits     = cmp_lhs <= tref;
  end

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      cscl_pkg::ST_IDLE:
        if (accept && sample.last_element) state_next = cscl_pkg::ST_CHECK;
      cscl_pkg::ST_CHECK:
        state_next = (zero_norm_now || !dot_pos) ? cscl_pkg::ST_DONE
                                                 : cscl_pkg::ST_MUL_P;
      cscl_pkg::ST_MUL_P:
        if (cnt == CNT_LAST) state_next = cscl_pkg::ST_MUL_T;
      cscl_pkg::ST_MUL_T:
        if (cnt == CNT_LAST) state_next = cscl_pkg::ST_CLAMP;
      cscl_pkg::ST_CLAMP:
        state_next = fits ? cscl_pkg::ST_DONE : cscl_pkg::ST_BIT_A;
      cscl_pkg::ST_BIT_A:
        state_next = cscl_pkg::ST_BIT_B;
      cscl_pkg::ST_BIT_B:
        state_next = cscl_pkg::ST_BIT_C;
      cscl_pkg::ST_BIT_C:
        state_next = (bit_k == '0) ? cscl_pkg::ST_DONE : cscl_pkg::ST_BIT_A;
      cscl_pkg::ST_DONE:
        if (!result_stall) state_next = cscl_pkg::ST_IDLE;
      default:
        state_next = cscl_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    sample_stall      = (state != cscl_pkg::ST_IDLE);
    result_valid      = (state == cscl_pkg::ST_DONE);
    result.similarity = sim;
    result.zero_norm  = zn;
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cscl_pkg::ST_IDLE;
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
    end else begin
      state      <= state_next;
      dot_sum    <= dot_sum_next;
      norm_a_sum <= norm_a_sum_next;
      norm_b_sum <= norm_b_sum_next;
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  //   MUL_P: P = na * nb by shift-add, MUL_T: T = dot^2 << 30.
  //   Bit loop for k = 14..0, s grows one bit at a time:
  //     A: tmp  = Q + (s*P << (k+1))
  //     B: cand = tmp + (P << 2k), keep when cand <= T
  //     C: s*P << (k+1) gets P << (2k+1) when kept, then both shift down
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      cscl_pkg::ST_CHECK: begin
        sim    <= '0;
        zn     <= zero_norm_now;
        acc    <= '0;
        mcand  <= WIDE_W'(norm_b_sum);
        mplier <= norm_a_sum;
        cnt    <= '0;
      end
      cscl_pkg::ST_MUL_P: begin
        if (cnt == CNT_LAST) begin
          pk     <= mul_next << (2 * (cscl_pkg::SIM_FRAC - 1));
          acc    <= '0;
          mcand  <= WIDE_W'(dot_sum) << (2 * cscl_pkg::SIM_FRAC);
          mplier <= dot_sum;
          cnt    <= '0;
        end else begin
          acc    <= mul_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
        end
      end
      cscl_pkg::ST_MUL_T: begin
        acc    <= mul_next;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_LAST) tref <= mul_next;
      end
      cscl_pkg::ST_CLAMP: begin
        if (fits) begin
          sim <= cscl_pkg::SIM_ONE;
        end else begin
          sim   <= '0;
          acc   <= '0;
          yv    <= '0;
          bit_k <= BIT_TOP;
        end
      end
      cscl_pkg::ST_BIT_A: begin
        mcand <= sum;
      end
      cscl_pkg::ST_BIT_B: begin
        take <= fits;
        if (fits) begin
          acc        <= sum;
          sim[bit_k] <= 1'b1;
        end
      end
      cscl_pkg::ST_BIT_C: begin
        yv <= sum >> 1;
        pk <= pk >> 2;
        if (bit_k != '0) bit_k <= bit_k - 1'b1;
      end
      default: begin
        take <= take;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a waiting result keeps new requests out
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_stall)
    else $error("request taken while result pending");

  // zero norm always reports zero similarity
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.zero_norm) |-> (result.similarity == '0))
    else $error("zero norm with nonzero similarity");

  // clamp upper bound
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.similarity <= cscl_pkg::SIM_ONE))
    else $error("similarity above one");

  // final pair starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && sample.last_element) |=> sample_stall)
    else $error("final request did not start computation");

  // sums are clear once a result has been taken
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall) |=>
      (dot_sum == '0 && norm_a_sum == '0 && norm_b_sum == '0))
    else $error("sums not cleared after result");
`endif

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cosine_similarity_clamped
// Streams element-pair requests into the block. A local fixed-point
// predictor keeps its own running sums and computes the expected clamped
// Q1.15 cosine for every closing pair. Each result the block hands over is
// checked field by field against the oldest expected one. The run walks
// through idle/stall phases. A short directed set comes before the random
// vectors.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // flavor of a random vector
  typedef enum int {
    VEC_RANDOM,
    VEC_ALIGNED,
    VEC_OPPOSED,
    VEC_EXTREME,
    VEC_SPARSE
  } vec_kind_t;

  // saturation bounds of the 44-bit sums
  localparam longint DOT_MAX  = (longint'(1) << 43) - 1;
  localparam longint DOT_MIN  = -(longint'(1) << 43);
  localparam longint NORM_MAX = (longint'(1) << 44) - 1;

  // wait for any stray result after the last drain; allow a good margin
  localparam int SETTLE_CYCLES = 400;
  // minimum random requests per idle/stall phase, four phases
  localparam int PHASE_ITEMS   = 104;

  localparam logic [cscl_pkg::SAMPLE_BITS-1:0] CORNER_VALUES [5] = '{
    16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF
  };

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  cscl_pkg::sample_t sample       = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  cscl_pkg::result_t result;

  // requests waiting to be driven, results still owed by the block
  cscl_pkg::sample_t pending_q[$];
  cscl_pkg::result_t expected_q[$];
  cscl_pkg::result_t oldest;

  // predictor copy of the running sums
  longint dot_acc    = 0;
  longint norm_a_acc = 0;
  longint norm_b_acc = 0;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int error_count   = 0;

  cosine_similarity_clamped uut (
    .clk,
    .rst,
    .sample_valid,
    .sample_stall,
    .sample,
    .result_valid,
    .result_stall,
    .result
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Largest s in [0, 32768] with s * sqrt(na * nb) <= 32768 * dot.
  // Squared on both sides: s^2 * na * nb <= 2^30 * dot^2, all in 128 bits.
  function automatic logic [cscl_pkg::SIM_W-1:0] cosine_q15(longint dot, longint na,
                                                              longint nb);
    logic [127:0]               prod;
    logic [127:0]               target;
    logic [cscl_pkg::SIM_W-1:0] s;
    logic [31:0]                c;
    if (dot <= 0) begin
      return '0;
    end
    prod   = 128'(na) * 128'(nb);
    target = (128'(dot) * 128'(dot)) << 30;
    // full scale clamp: cos >= 1.0
    if ((prod << 30) <= target) begin
      return cscl_pkg::SIM_ONE;
    end
    // restoring search from the top fraction bit down
    s = '0;
    for (int k = cscl_pkg::SIM_FRAC - 1; k >= 0; k--) begin
      c = {16'b0, s} | (32'd1 << k);
      if (prod * 128'(c * c) <= target) begin
        s = c[cscl_pkg::SIM_W-1:0];
      end
    end
    return s;
  endfunction

  // Fold one accepted pair into the sums; a closing pair yields a result.
  task automatic absorb_pair(input cscl_pkg::sample_t s);
    longint            a;
    longint            b;
    longint            d;
    cscl_pkg::result_t r;
    a = longint'($signed(s.a_value));
    b = longint'($signed(s.b_value));
    d = dot_acc + a * b;
    if (d > DOT_MAX) d = DOT_MAX;
    if (d < DOT_MIN) d = DOT_MIN;
    dot_acc    = d;
    norm_a_acc = norm_a_acc + a * a;
    if (norm_a_acc > NORM_MAX) norm_a_acc = NORM_MAX;
    norm_b_acc = norm_b_acc + b * b;
    if (norm_b_acc > NORM_MAX) norm_b_acc = NORM_MAX;
    if (s.last_element) begin
      if (norm_a_acc == 0 || norm_b_acc == 0) begin
        // zero norm: flag it, similarity forced to 0
        r.similarity = '0;
        r.zero_norm  = 1'b1;
      end else begin
        r.similarity = cosine_q15(dot_acc, norm_a_acc, norm_b_acc);
        r.zero_norm  = 1'b0;
      end
      expected_q.push_back(r);
      dot_acc    = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
    end
  endtask

  task automatic queue_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
    cscl_pkg::sample_t s;
    s.a_value      = a;
    s.b_value      = b;
    s.last_element = last;
    pending_q.push_back(s);
  endtask

  task automatic queue_vector(input int len, input vec_kind_t kind);
    logic [15:0] a;
    logic [15:0] b;
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (kind)
        VEC_ALIGNED: begin
          // same direction with a little noise: lands on or near full scale
          b = a + 16'($urandom_range(0, 4)) - 16'd2;
        end
        VEC_OPPOSED: begin
          b = -a;
        end
        VEC_EXTREME: begin
          a = CORNER_VALUES[$urandom_range(0, 4)];
          b = CORNER_VALUES[$urandom_range(0, 4)];
        end
        VEC_SPARSE: begin
          // zeros everywhere: often an all-zero vector on one side
          if ($urandom_range(0, 1) == 0) a = '0;
          if ($urandom_range(0, 2) != 0) b = '0;
        end
        default: begin
        end
      endcase
      queue_pair(a, b, i == len - 1);
    end
  endtask

  // Random vectors until at least 'target' requests are queued.
  task automatic queue_random(input int target);
    int        queued;
    int        len;
    int        pick;
    vec_kind_t kind;
    queued = 0;
    while (queued < target) begin
      // mostly short vectors so results come often
      len  = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      pick = $urandom_range(0, 99);
      if (pick < 35)      kind = VEC_RANDOM;
      else if (pick < 60) kind = VEC_ALIGNED;
      else if (pick < 70) kind = VEC_OPPOSED;
      else if (pick < 85) kind = VEC_EXTREME;
      else                kind = VEC_SPARSE;
      queue_vector(len, kind);
      queued += len;
    end
  endtask

  // Wait until every request went in and every owed result came back.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_q.size() != 0 || sample_valid || expected_q.size() != 0);
  endtask

  // Request driver: the held request stays put while stalled; once the slot
  // is free the next one goes out unless this cycle is an idle one.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        absorb_pair(sample);
      end
      if (!sample_valid || !sample_stall) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          sample       <= pending_q.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest
  // expectation, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected: similarity %0d zero_norm %0b",
                   $time, result.similarity, result.zero_norm);
          error_count++;
        end else begin
          oldest = expected_q.pop_front();
          if (result.similarity !== oldest.similarity) begin
            $display("%0t: similarity expected %0d, got %0d",
                     $time, oldest.similarity, result.similarity);
            error_count++;
          end
          if (result.zero_norm !== oldest.zero_norm) begin
            $display("%0t: zero_norm expected %0b, got %0b",
                     $time, oldest.zero_norm, result.zero_norm);
            error_count++;
          end
        end
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests, no idling.
    queue_pair(16'h7FFF, 16'h7FFF, 1'b1);   // largest positive pair: full scale
    queue_pair(16'h8000, 16'h8000, 1'b1);   // most negative pair: full scale
    queue_pair(16'h8000, 16'h7FFF, 1'b1);   // negative dot: zero, no flag
    queue_pair(16'h0000, 16'h0005, 1'b1);   // first norm zero
    queue_pair(16'h0007, 16'h0000, 1'b1);   // second norm zero
    queue_pair(16'h0000, 16'h0000, 1'b1);   // both norms zero
    queue_pair(16'h0001, 16'h0000, 1'b0);   // orthogonal: dot exactly zero
    queue_pair(16'h0000, 16'h0001, 1'b1);
    queue_pair(16'hFFFF, 16'h0001, 1'b1);   // smallest negative dot
    queue_pair(16'h0001, 16'h0001, 1'b1);   // smallest positive pair
    queue_pair(16'h5555, 16'hAAAA, 1'b0);   // alternating bit patterns
    queue_pair(16'hAAAA, 16'h5555, 1'b1);
    queue_pair(16'h7FFF, 16'h7FFE, 1'b0);   // cosine close to 1/sqrt(2)
    queue_pair(16'h0001, 16'h8000, 1'b1);
    queue_pair(16'h3000, 16'h1000, 1'b0);   // mid-range cosine
    queue_pair(16'h1000, 16'h3000, 1'b1);
    drain();

    // Random vectors through the idle/stall phases.
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 80;
    stall_pct     = 0;
    queue_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    stall_pct     = 80;
    queue_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 31;
    stall_pct     = 31;
    queue_random(PHASE_ITEMS);
    drain();

    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/cscl_pkg.sv
hdl/cosine_similarity_clamped.sv
bench/testbench.sv
